// ----- sv/rpc_pkg.sv -----
// Shared types and constants for the rotate-point-about-center unit.
// CORDIC sizing, arctangent table and configuration register indexes.
// No dependencies.
package rpc_pkg;

  // CORDIC engine sizing (fixed, independent of the coordinate format)
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_XW    = 33;
  localparam int CORDIC_ZW    = 34;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN_INV = 33'sh26DD_3B6A;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE    = 2'd0,
    CFG_EXTENT_X = 2'd1,
    CFG_EXTENT_Y = 2'd2
  } cfg_idx_e;

  // atan(2^-i) in turns scaled by 2^32
  function automatic logic [31:0] atan_turns(input logic [STEP_W-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h2000_0000;
      5'd1:  r = 32'h12E4_051E;
      5'd2:  r = 32'h09FB_385B;
      5'd3:  r = 32'h0511_11D4;
      5'd4:  r = 32'h028B_0D43;
      5'd5:  r = 32'h0145_D7E1;
      5'd6:  r = 32'h00A2_F61E;
      5'd7:  r = 32'h0051_7C55;
      5'd8:  r = 32'h0028_BE53;
      5'd9:  r = 32'h0014_5F2F;
      5'd10: r = 32'h000A_2F98;
      5'd11: r = 32'h0005_17CC;
      5'd12: r = 32'h0002_8BE6;
      5'd13: r = 32'h0001_45F3;
      5'd14: r = 32'h0000_A2FA;
      5'd15: r = 32'h0000_517D;
      5'd16: r = 32'h0000_28BE;
      5'd17: r = 32'h0000_145F;
      5'd18: r = 32'h0000_0A30;
      5'd19: r = 32'h0000_0518;
      5'd20: r = 32'h0000_028C;
      5'd21: r = 32'h0000_0146;
      5'd22: r = 32'h0000_00A3;
      5'd23: r = 32'h0000_0051;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/rpc_vertex_if.sv -----
// Vertex input channel: valid/ready handshake with a signed Q16.8 (x, y) pair.
// No dependencies.
interface rpc_vertex_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;

  modport source (output valid, output vertex_x, output vertex_y, input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, output ready);
endinterface

// ----- sv/rpc_result_if.sv -----
// Result output channel: valid/ready handshake with the rotated vertex and clip flag.
// No dependencies.
interface rpc_result_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] rotated_x;
  logic signed [COORD_BITS-1:0] rotated_y;
  logic                         clipped;

  modport source (output valid, output rotated_x, output rotated_y, output clipped,
                  input ready);
  modport sink   (input valid, input rotated_x, input rotated_y, input clipped,
                  output ready);
endinterface

// ----- sv/rpc_cordic.sv -----
// Iterative CORDIC: turns the rotation angle into rounded cos/sin.
// One micro-rotation per cycle. Depends on rpc_pkg.
module rpc_cordic import rpc_pkg::*; #(
  parameter int ANGLE_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 15,
  localparam int TW            = TRIG_FRAC_BITS + 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  output logic                  ready_o,
  output logic signed [TW-1:0]  cos_o,
  output logic signed [TW-1:0]  sin_o
);

  localparam int SH = CORDIC_FRAC - TRIG_FRAC_BITS;
  localparam logic signed [CORDIC_XW-1:0] HALF = CORDIC_XW'(1) <<< (SH - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    CS_LOAD  = 4'b0001,
    CS_ITER  = 4'b0010,
    CS_ROUND = 4'b0100,
    CS_DONE  = 4'b1000
  } cordic_state_e;

  cordic_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic neg_q, neg_d;
  logic signed [CORDIC_XW-1:0] x_q, x_d, y_q, y_d;
  logic signed [CORDIC_ZW-1:0] z_q, z_d;
  logic signed [TW-1:0] cos_q, cos_d, sin_q, sin_d;

  // quadrant fold: second/third quadrant rotate by half a turn, negate later
  logic [31:0] turn, turn_q1, turn_f;
  logic        fold;
  logic signed [CORDIC_XW-1:0] xs, ys, xn, yn, xr, yr, xsh, ysh;
  logic signed [CORDIC_ZW-1:0] at;

  always_comb begin
    turn    = 32'(angle_i) << (32 - ANGLE_BITS);
    turn_q1 = turn + 32'h4000_0000;
    fold    = turn_q1[31];
    turn_f  = {turn[31] ^ fold, turn[30:0]};

    xs = x_q >>> step_q;
    ys = y_q >>> step_q;
    at = $signed({2'b00, atan_turns(step_q)});

    xn  = neg_q ? -x_q : x_q;
    yn  = neg_q ? -y_q : y_q;
    xr  = xn + HALF;
    yr  = yn + HALF;
    xsh = xr >>> SH;
    ysh = yr >>> SH;
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    neg_d   = neg_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    cos_d   = cos_q;
    sin_d   = sin_q;
    case (state_q)
      CS_LOAD: begin
        x_d     = CORDIC_GAIN_INV;
        y_d     = '0;
        z_d     = CORDIC_ZW'($signed(turn_f));
        neg_d   = fold;
        step_d  = '0;
        state_d = CS_ITER;
      end
      CS_ITER: begin
        if (!z_q[CORDIC_ZW-1]) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - at;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + at;
        end
        step_d = step_q + STEP_W'(1);
        if (step_q == LAST_STEP) begin
          state_d = CS_ROUND;
        end
      end
      CS_ROUND: begin
        cos_d   = xsh[TW-1:0];
        sin_d   = ysh[TW-1:0];
        state_d = CS_DONE;
      end
      CS_DONE: begin
        state_d = CS_DONE;
      end
      default: begin
        state_d = CS_LOAD;
      end
    endcase
    if (start_i) begin
      state_d = CS_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_LOAD;
      step_q  <= '0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      neg_q   <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    cos_q <= cos_d;
    sin_q <= sin_d;
  end

  assign ready_o = (state_q == CS_DONE) && !start_i;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;

endmodule

// ----- sv/rpc_datapath.sv -----
// Four-stage rotation pipeline: center offset, matrix products, round, saturate.
// Each stage has its own valid bit and ready. Depends on rpc_pkg and the channel interfaces.
module rpc_datapath import rpc_pkg::*; #(
  parameter int COORD_BITS     = 24,
  parameter int TRIG_FRAC_BITS = 15,
  localparam int TW            = TRIG_FRAC_BITS + 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  trig_ready_i,
  input  logic signed [TW-1:0]  cos_i,
  input  logic signed [TW-1:0]  sin_i,
  input  logic [COORD_BITS-2:0] extent_x_i,
  input  logic [COORD_BITS-2:0] extent_y_i,
  rpc_vertex_if.sink            vertex_i,
  rpc_result_if.source          result_o
);

  localparam int C  = COORD_BITS;
  localparam int DW = C + 2;
  localparam int PW = DW + TW;
  localparam int SW = PW + 1;
  localparam int RW = SW - TRIG_FRAC_BITS - 1;
  localparam logic signed [SW-1:0] ONE = SW'(1);

  // stage valids and readies
  logic v1_q, v2_q, v3_q, vo_q;
  logic rdy0, rdy1, rdy2, rdy3;
  logic in_fire;

  assign rdy3    = !vo_q || result_o.ready;
  assign rdy2    = !v3_q || rdy3;
  assign rdy1    = !v2_q || rdy2;
  assign rdy0    = !v1_q || rdy1;
  assign vertex_i.ready = rdy0 && trig_ready_i;
  assign in_fire = vertex_i.valid && vertex_i.ready;

  // stage 1: doubled offsets from center
  logic signed [DW-1:0] dx_d, dy_d, dx_q, dy_q;
  assign dx_d = $signed({vertex_i.vertex_x[C-1], vertex_i.vertex_x, 1'b0})
              - $signed({3'b000, extent_x_i});
  assign dy_d = $signed({vertex_i.vertex_y[C-1], vertex_i.vertex_y, 1'b0})
              - $signed({3'b000, extent_y_i});

  // stage 2: matrix products
  logic signed [PW-1:0] p_xc_q, p_ys_q, p_xs_q, p_yc_q;

  // stage 3: sums with center and rounding bias, then scale down
  logic signed [SW-1:0] bx, by, sx, sy, sxs, sys;
  logic signed [RW-1:0] rx_q, ry_q;
  assign bx  = ($signed(SW'({1'b0, extent_x_i})) + ONE) <<< TRIG_FRAC_BITS;
  assign by  = ($signed(SW'({1'b0, extent_y_i})) + ONE) <<< TRIG_FRAC_BITS;
  assign sx  = SW'(p_xc_q) - SW'(p_ys_q) + bx;
  assign sy  = SW'(p_xs_q) + SW'(p_yc_q) + by;
  assign sxs = sx >>> (TRIG_FRAC_BITS + 1);
  assign sys = sy >>> (TRIG_FRAC_BITS + 1);

  // stage 4: saturation into the output register
  logic fit_x, fit_y;
  logic signed [C-1:0] ox_d, oy_d, ox_q, oy_q;
  logic clip_q;
  assign fit_x = (&rx_q[RW-1:C-1]) || !(|rx_q[RW-1:C-1]);
  assign fit_y = (&ry_q[RW-1:C-1]) || !(|ry_q[RW-1:C-1]);
  assign ox_d  = fit_x ? rx_q[C-1:0]
                       : (rx_q[RW-1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}});
  assign oy_d  = fit_y ? ry_q[C-1:0]
                       : (ry_q[RW-1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy0) v1_q <= in_fire;
      if (rdy1) v2_q <= v1_q;
      if (rdy2) v3_q <= v2_q;
      if (rdy3) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (rdy1 && v1_q) begin
      p_xc_q <= PW'(dx_q) * PW'(cos_i);
      p_ys_q <= PW'(dy_q) * PW'(sin_i);
      p_xs_q <= PW'(dx_q) * PW'(sin_i);
      p_yc_q <= PW'(dy_q) * PW'(cos_i);
    end
    if (rdy2 && v2_q) begin
      rx_q <= sxs[RW-1:0];
      ry_q <= sys[RW-1:0];
    end
    if (rdy3 && v3_q) begin
      ox_q   <= ox_d;
      oy_q   <= oy_d;
      clip_q <= !fit_x || !fit_y;
    end
  end

  assign result_o.valid     = vo_q;
  assign result_o.rotated_x = ox_q;
  assign result_o.rotated_y = oy_q;
  assign result_o.clipped   = clip_q;

endmodule

// ----- sv/rotate_point_about_center_unit.sv -----
// Rotate-point-about-center unit: one vertex in, one rotated vertex out, per transfer.
// Depends on rpc_pkg, rpc_vertex_if, rpc_result_if, rpc_cordic and rpc_datapath.
//
// Sustained rate is one vertex transfer per clock while cos/sin are ready and results
// are taken; a result passes through the stages center offset, four matrix multipliers,
// round/scale and saturate into the output register, and each stage has its own
// valid bit, so a stalled result does not block new input until the pipe fills.
// cos/sin come from an iterative CORDIC that does one micro-rotation per cycle:
// after reset and after every rotation_angle write it runs load, 24 steps and
// round with vertex_i.ready low. Extent writes take effect at once.
// Write the registers only while no vertex is in flight.
module rotate_point_about_center_unit import rpc_pkg::*; #(
  parameter int COORD_BITS     = 24,
  parameter int ANGLE_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 15,
  localparam int CFG_W = (ANGLE_BITS > COORD_BITS - 1) ? ANGLE_BITS : COORD_BITS - 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  rpc_vertex_if.sink           vertex_i,
  rpc_result_if.source         result_o
);

  localparam int TW = TRIG_FRAC_BITS + 2;

  // configuration registers
  logic [ANGLE_BITS-1:0] angle_q;
  logic [COORD_BITS-2:0] extent_x_q, extent_y_q;
  logic                  angle_wr;

  assign angle_wr = cfg_we_i && (cfg_index_i == CFG_ANGLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q    <= '0;
      extent_x_q <= '0;
      extent_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ANGLE:    angle_q    <= cfg_data_i[ANGLE_BITS-1:0];
        CFG_EXTENT_X: extent_x_q <= cfg_data_i[COORD_BITS-2:0];
        CFG_EXTENT_Y: extent_y_q <= cfg_data_i[COORD_BITS-2:0];
        default: ; // unknown index: write dropped
      endcase
    end
  end

  // trig unit; restarts on every angle write
  logic                 trig_ready;
  logic signed [TW-1:0] cos_v, sin_v;

  rpc_cordic #(
    .ANGLE_BITS    (ANGLE_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(angle_wr),
    .angle_i(angle_q),
    .ready_o(trig_ready),
    .cos_o  (cos_v),
    .sin_o  (sin_v)
  );

  // rotation pipeline; input held off until cos/sin are settled
  rpc_datapath #(
    .COORD_BITS    (COORD_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .trig_ready_i(trig_ready),
    .cos_i       (cos_v),
    .sin_i       (sin_v),
    .extent_x_i  (extent_x_q),
    .extent_y_i  (extent_y_q),
    .vertex_i    (vertex_i),
    .result_o    (result_o)
  );

endmodule

// ----- sv/rpc_checker.sv -----
// Port-level assertions for the rotate-point-about-center unit, bound to the top level.
// Depends on rpc_pkg.
module rpc_checker import rpc_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic signed [COORD_BITS-1:0] out_x_i,
  input logic signed [COORD_BITS-1:0] out_y_i,
  input logic                         out_clip_i,
  input logic                         cfg_we_i,
  input logic [CFG_IDX_W-1:0]         cfg_index_i
);

  localparam logic signed [COORD_BITS-1:0] MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({out_x_i, out_y_i, out_clip_i}))
    else $error("stalled result changed");

  a_angle_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_index_i == CFG_ANGLE) |=> !in_ready_i)
    else $error("vertex taken while cos/sin recomputed");

  a_clip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_clip_i |->
      (out_x_i == MAXV) || (out_x_i == MINV) || (out_y_i == MAXV) || (out_y_i == MINV))
    else $error("clip flag without a saturated coordinate");

endmodule

bind rotate_point_about_center_unit rpc_checker #(
  .COORD_BITS(COORD_BITS)
) u_rpc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (vertex_i.ready),
  .out_valid_i(result_o.valid),
  .out_ready_i(result_o.ready),
  .out_x_i    (result_o.rotated_x),
  .out_y_i    (result_o.rotated_y),
  .out_clip_i (result_o.clipped),
  .cfg_we_i   (cfg_we_i),
  .cfg_index_i(cfg_index_i)
);
